@@ src/short_branch_relocator_assert.svh @@
// Assertion macros for the short branch relocator.
// Depends on nothing; expects clk and rst_n in the scope where a macro is used.
`ifndef SHORT_BRANCH_RELOCATOR_ASSERT_SVH
`define SHORT_BRANCH_RELOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define SBR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The condition must never be seen outside reset.
`define SBR_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SBR_ASSERT(lbl, prop, msg)
`define SBR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ src/sbr_pkg.sv @@
// Shared types, constants and byte-encoding functions of the short branch relocator.
// Depends on nothing; used by the interfaces and every module.
package sbr_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_NOT_HANDLED = 2'd0,
        ST_HANDLED     = 2'd1,
        ST_FAILED      = 2'd2
    } status_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_BLOCK_BASE = 2'd0,
        REG_BLOCK_SIZE = 2'd1,
        REG_LONG_MODE  = 2'd2
    } reg_idx_t;

    // Encoding chosen for one instruction.
    typedef enum logic [2:0] {
        K_SINGLE = 3'd0,
        K_JMP32  = 3'd1,
        K_JCC32  = 3'd2,
        K_JMPABS = 3'd3,
        K_JCCABS = 3'd4
    } kind_t;

    // One classified instruction, as held in the queue.
    typedef struct packed {
        status_t      status;
        kind_t        kind;
        logic [3:0]   cc;
        logic [31:0]  rel;
        logic [63:0]  target;
        logic [16:0]  new_off;
    } sbr_job_t;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] OP_JMP32   = 8'hE9;
    localparam logic [7:0] OP_TWOBYTE = 8'h0F;
    localparam logic [3:0] HI_JCC32   = 4'h8;
    localparam logic [3:0] HI_JCC8    = 4'h7;
    localparam logic [7:0] OP_JMP8    = 8'hEB;
    localparam logic [7:0] OP_GRP5    = 8'hFF;
    localparam logic [7:0] MODRM_RIP  = 8'h25;
    localparam logic [7:0] ABS_JUMP_BYTES = 8'd14;

    // Number of results an encoding produces.
    function automatic logic [4:0] job_len(input kind_t kind);
        logic [4:0] n;
        unique case (kind)
            K_JMP32:  n = 5'd5;
            K_JCC32:  n = 5'd6;
            K_JMPABS: n = 5'd14;
            K_JCCABS: n = 5'd16;
            default:  n = 5'd1;
        endcase
        return n;
    endfunction

    // Byte i of the 14-byte indirect jump through an inline absolute address.
    function automatic logic [7:0] abs_byte(input logic [63:0] target, input logic [3:0] i);
        logic [3:0] k;
        logic [7:0] b;
        k = i - 4'd6;
        case (i) inside
            4'd0:          b = OP_GRP5;
            4'd1:          b = MODRM_RIP;
            [4'd2:4'd5]:   b = 8'h00;
            default:       b = target[{k[2:0], 3'b000} +: 8];
        endcase
        return b;
    endfunction

    // Byte i of the encoding held in a job.
    function automatic logic [7:0] job_byte(input sbr_job_t job, input logic [3:0] i);
        logic [3:0] k1;
        logic [3:0] k2;
        logic [7:0] b;
        k1 = i - 4'd1;
        k2 = i - 4'd2;
        unique case (job.kind)
            K_JMP32:
            begin
                b = (i == 4'd0) ? OP_JMP32 : job.rel[{k1[1:0], 3'b000} +: 8];
            end
            K_JCC32:
            begin
                case (i) inside
                    4'd0:    b = OP_TWOBYTE;
                    4'd1:    b = {HI_JCC32, job.cc};
                    default: b = job.rel[{k2[1:0], 3'b000} +: 8];
                endcase
            end
            K_JMPABS:
            begin
                b = abs_byte(job.target, i);
            end
            K_JCCABS:
            begin
                case (i) inside
                    4'd0:    b = {HI_JCC8, job.cc ^ 4'h1};
                    4'd1:    b = ABS_JUMP_BYTES;
                    default: b = abs_byte(job.target, k2);
                endcase
            end
            default:
            begin
                b = 8'h00;
            end
        endcase
        return b;
    endfunction

endpackage

@@ src/sbr_if.sv @@
// Valid/ready channel interfaces: instruction items, result items and register writes.
// Depends on sbr_pkg.
interface sbr_instr_if import sbr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [7:0]         opcode_byte;
    logic signed [7:0]  displacement;
    logic [63:0]        instr_address;
    logic [3:0]         instr_length;
    logic [63:0]        trampoline_base;
    logic [15:0]        write_offset;

    modport source (output valid, opcode_byte, displacement, instr_address, instr_length,
                    trampoline_base, write_offset, input ready);
    modport sink   (input valid, opcode_byte, displacement, instr_address, instr_length,
                    trampoline_base, write_offset, output ready);
endinterface

interface sbr_result_if import sbr_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [16:0] new_write_offset;

    modport source (output valid, status, out_byte, byte_valid, last, new_write_offset,
                    input ready);
    modport sink   (input valid, status, out_byte, byte_valid, last, new_write_offset,
                    output ready);
endinterface

interface sbr_cfg_if import sbr_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/sbr_queue.sv @@
// Four-entry job queue between the classifying front end and the byte emitter.
// Depends on sbr_pkg and the assertion macro header.
`include "short_branch_relocator_assert.svh"
module sbr_queue import sbr_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  sbr_job_t push_job,
    output logic     full,
    input  logic     pop,
    output sbr_job_t head_job,
    output logic     empty
);

    sbr_job_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `SBR_ASSERT(a_count_bound, count_reg <= QCNT_W'(QDEPTH), "queue count beyond depth")
    `SBR_ASSERT_NEVER(a_pop_empty, pop && empty, "pop from empty queue")

endmodule

@@ src/sbr_front.sv @@
// Front end: configuration registers, target and reach computation, classification.
// Depends on sbr_pkg and the channel interfaces.
module sbr_front import sbr_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    sbr_cfg_if.sink       cfg,
    sbr_instr_if.sink     instr,
    input  logic          q_full,
    output logic          q_push,
    output sbr_job_t      q_job
);

    typedef enum logic [1:0] {
        C_OTHER = 2'd0,
        C_JCC   = 2'd1,
        C_JMP   = 2'd2,
        C_LOOP  = 2'd3
    } class_t;

    logic [63:0] block_base_reg;
    logic [7:0]  block_size_reg;
    logic        long_mode_reg;

    logic        s1_valid_reg;
    logic        s1_bad_reg;
    class_t      s1_cls_reg;
    logic [3:0]  s1_cc_reg;
    logic [63:0] s1_target_reg;
    logic [63:0] s1_here_reg;
    logic [63:0] s1_end_reg;
    logic [15:0] s1_off_reg;

    class_t      cls;
    logic        s1_load;
    logic        in_block;
    logic        fits;
    logic [63:0] rel_span;

    assign cfg.ready   = 1'b1;
    assign instr.ready = !s1_valid_reg || !q_full;
    assign s1_load     = instr.valid && instr.ready;
    assign q_push      = s1_valid_reg && !q_full;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_base_reg <= '0;
            block_size_reg <= '0;
            long_mode_reg  <= 1'b1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_BLOCK_BASE: block_base_reg <= cfg.data;
                REG_BLOCK_SIZE: block_size_reg <= cfg.data[7:0];
                REG_LONG_MODE:  long_mode_reg  <= cfg.data[0];
                default:        ;
            endcase
        end
    end

    // Opcode decode.
    always_comb
    begin
        unique case (instr.opcode_byte) inside
            [8'h70:8'h7F]: cls = C_JCC;
            OP_JMP8:       cls = C_JMP;
            [8'hE0:8'hE3]: cls = C_LOOP;
            default:       cls = C_OTHER;
        endcase
    end

    // Stage one: branch target, end of block, and the address after the rel32 form.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (instr.ready)
        begin
            s1_valid_reg <= instr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_bad_reg    <= (instr.instr_length < 4'd2) || (instr.trampoline_base == '0);
            s1_cls_reg    <= cls;
            s1_cc_reg     <= instr.opcode_byte[3:0];
            s1_target_reg <= instr.instr_address + {60'd0, instr.instr_length}
                             + {{56{instr.displacement[7]}}, instr.displacement};
            s1_here_reg   <= instr.trampoline_base + {48'd0, instr.write_offset}
                             + ((cls == C_JCC) ? 64'd6 : 64'd5);
            s1_end_reg    <= block_base_reg + {56'd0, block_size_reg};
            s1_off_reg    <= instr.write_offset;
        end
    end

    // Stage two: block and reach tests, choice of encoding.
    assign rel_span = s1_target_reg - s1_here_reg;
    assign fits     = (rel_span[63:31] == '0) || (rel_span[63:31] == '1);
    assign in_block = (s1_target_reg >= block_base_reg) && (s1_target_reg < s1_end_reg);

    always_comb
    begin
        q_job.status  = ST_NOT_HANDLED;
        q_job.kind    = K_SINGLE;
        q_job.cc      = s1_cc_reg;
        q_job.rel     = rel_span[31:0];
        q_job.target  = s1_target_reg;
        q_job.new_off = {1'b0, s1_off_reg};
        if (s1_bad_reg || (s1_cls_reg == C_OTHER) || in_block)
        begin
            q_job.status = ST_NOT_HANDLED;
        end
        else if (s1_cls_reg == C_LOOP)
        begin
            q_job.status = ST_FAILED;
        end
        else if (fits || long_mode_reg)
        begin
            q_job.status = ST_HANDLED;
            if (s1_cls_reg == C_JMP)
            begin
                q_job.kind = fits ? K_JMP32 : K_JMPABS;
            end
            else
            begin
                q_job.kind = fits ? K_JCC32 : K_JCCABS;
            end
            q_job.new_off = {1'b0, s1_off_reg} + {12'd0, job_len(q_job.kind)};
        end
        else
        begin
            q_job.status = ST_FAILED;
        end
    end

endmodule

@@ src/sbr_back.sv @@
// Back end: walks the job at the head of the queue and emits one result item per byte, or a single byteless item.
// Depends on sbr_pkg, the result interface and the assertion macro header.
`include "short_branch_relocator_assert.svh"
module sbr_back import sbr_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  sbr_job_t       head_job,
    input  logic           q_empty,
    output logic           q_pop,
    sbr_result_if.source   result
);

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [7:0]  byte_reg;
    logic        bvalid_reg;
    logic        last_reg;
    logic [16:0] off_reg;
    logic [3:0]  idx_reg, idx_next;

    logic        load;
    logic        emit;
    logic        is_last;
    logic [4:0]  len;

    assign load    = !out_valid_reg || result.ready;
    assign emit    = load && !q_empty;
    assign len     = job_len(head_job.kind);
    assign is_last = ({1'b0, idx_reg} == (len - 5'd1));
    assign q_pop   = emit && is_last;
    assign idx_next = is_last ? 4'd0 : idx_reg + 4'd1;

    assign result.valid            = out_valid_reg;
    assign result.status           = status_reg;
    assign result.out_byte         = byte_reg;
    assign result.byte_valid       = bvalid_reg;
    assign result.last             = last_reg;
    assign result.new_write_offset = off_reg;

    // Byte counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= !q_empty;
            if (emit)
            begin
                idx_reg <= idx_next;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= head_job.status;
            byte_reg   <= job_byte(head_job, idx_reg);
            bvalid_reg <= (head_job.kind != K_SINGLE);
            last_reg   <= is_last;
            off_reg    <= head_job.new_off;
        end
    end

    `SBR_ASSERT(a_head_held, (idx_reg != 4'd0) |-> !q_empty, "job left queue mid-emit")
    `SBR_ASSERT(a_single_last, (out_valid_reg && !bvalid_reg) |-> last_reg,
                "byteless result not marked last")

endmodule

@@ src/short_branch_relocator.sv @@
// Short branch relocator top level: front end, job queue and byte emitter.
// Depends on sbr_pkg, the channel interfaces, sbr_front, sbr_queue and sbr_back.
//
// Usage: instructions arrive on the instr channel (valid/ready) with opcode,
// rel8 displacement, address, length, trampoline base and write offset.
// Results leave on the result channel, one item per emitted byte (5, 6, 14
// or 16 items), or a single byteless item when the instruction is not handled
// or the relocation fails; last marks the final item of an instruction.
// Registers are written on the cfg channel (index 0 block base, 1 block size,
// 2 long mode), which is always ready and must only be used while idle.
// The first result of an instruction passes through the stage-one registers,
// the queue and the output register when the block is empty. Throughput is
// one result per cycle while the receiver is ready; the emitter's byte
// counter sets that rate. The front end takes a new instruction every cycle
// while the four-entry queue has room.
// Reset clears the pipeline and queue and sets block base 0, size 0 and long
// mode 1. When the receiver stalls, the current result is held and the queue
// fills, after which instr.ready drops.
module short_branch_relocator import sbr_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    sbr_cfg_if.sink       cfg,
    sbr_instr_if.sink     instr,
    sbr_result_if.source  result
);

    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    sbr_job_t push_job;
    sbr_job_t head_job;

    // Classification and encoding choice.
    sbr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .instr  (instr),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (push_job)
    );

    // Decoupling queue.
    sbr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    // Byte emission.
    sbr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .result   (result)
    );

endmodule

@@ verif/short_branch_relocator_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the short branch relocator: directed and random instructions
// with random idling on both channels, checked byte by byte against a scoreboard predictor.
// Depends on sbr_pkg, the channel interfaces in sbr_if.sv and the short_branch_relocator RTL.
module short_branch_relocator_tb;
    import sbr_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 4;
    localparam int MAX_IDLE        = 10;
    localparam int DRAIN_CYCLES    = 10;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 30;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int MAX_REPORTS     = 10;

    // Opcodes the testbench needs beyond those in the package.
    localparam logic [7:0] OP_LOOP_FIRST = 8'hE0;
    localparam logic [7:0] OP_LOOPE      = 8'hE1;
    localparam logic [7:0] OP_LOOP       = 8'hE2;
    localparam logic [7:0] OP_JCXZ       = 8'hE3;
    localparam logic [7:0] OP_NOP        = 8'h90;

    // One instruction as offered on the instruction channel.
    typedef struct packed {
        logic [7:0]        opcode;
        logic signed [7:0] disp;
        logic [63:0]       addr;
        logic [3:0]        len;
        logic [63:0]       tbase;
        logic [15:0]       off;
    } instr_item_t;

    // One emitted trampoline byte, or the single byteless verdict.
    typedef struct packed {
        status_t     status;
        logic [7:0]  data;
        logic        present;
        logic        last;
        logic [16:0] new_off;
    } reloc_byte_t;

    // Predicts the relocated encoding of each accepted instruction and checks the bytes.
    class branch_relocation_checker;
        logic [63:0] block_base;
        logic [7:0]  block_size;
        logic        long_mode;
        reloc_byte_t expected_bytes[$];
        int          mismatches;
        int          bytes_checked;
        int          relocated;
        int          failed;
        int          passed_over;
        int          settings_used;

        function new();
            block_base    = '0;
            block_size    = '0;
            long_mode     = 1'b1;
            mismatches    = 0;
            bytes_checked = 0;
            relocated     = 0;
            failed        = 0;
            passed_over   = 0;
            settings_used = 1;
        endfunction

        function void set_register(reg_idx_t idx, logic [63:0] value);
            case (idx)
                REG_BLOCK_BASE: block_base = value;
                REG_BLOCK_SIZE: block_size = value[7:0];
                REG_LONG_MODE:  long_mode  = value[0];
                default:        ;
            endcase
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Appends one expected result at the tail of the queue.
        function void queue_byte(reloc_byte_t b);
            expected_bytes.insert(expected_bytes.size(), b);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        // Works out the trampoline bytes for one instruction and queues them.
        function void note_instruction(instr_item_t it);
            logic [7:0]  enc[16];
            int          n;
            int          i;
            status_t     st;
            logic [63:0] target;
            logic [63:0] blk_end;
            logic [63:0] here;
            logic [63:0] rel_span;
            logic        is_jcc;
            logic        is_jmp;
            logic        is_loop;
            logic        fits;
            logic [3:0]  cc;
            logic [16:0] noff;
            reloc_byte_t item;
            n       = 0;
            st      = ST_NOT_HANDLED;
            is_jcc  = it.opcode[7:4] == HI_JCC8;
            is_jmp  = it.opcode == OP_JMP8;
            is_loop = it.opcode >= OP_LOOP_FIRST && it.opcode <= OP_JCXZ;
            cc      = it.opcode[3:0];
            target  = it.addr + 64'(it.len) + {{56{it.disp[7]}}, it.disp};
            blk_end = block_base + 64'(block_size);
            here    = it.tbase + 64'(it.off);
            if (it.len < 4'd2 || it.tbase == '0 || !(is_jcc || is_jmp || is_loop))
                st = ST_NOT_HANDLED;
            else if (target >= block_base && target < blk_end)
                st = ST_NOT_HANDLED;
            else if (is_loop)
                st = ST_FAILED;
            else
            begin
                rel_span = target - here - (is_jmp ? 64'd5 : 64'd6);
                fits = rel_span <= 64'h0000_0000_7FFF_FFFF ||
                       rel_span >= 64'hFFFF_FFFF_8000_0000;
                if (fits)
                begin
                    // Near form: opcode bytes then the little-endian rel32.
                    if (is_jmp)
                    begin
                        enc[0] = OP_JMP32;
                        n = 1;
                    end
                    else
                    begin
                        enc[0] = OP_TWOBYTE;
                        enc[1] = {HI_JCC32, cc};
                        n = 2;
                    end
                    for (i = 0; i < 4; i++)
                        enc[n + i] = rel_span[8 * i +: 8];
                    n  = n + 4;
                    st = ST_HANDLED;
                end
                else if (long_mode)
                begin
                    // Far form: an inverted short Jcc skips the absolute jump when needed.
                    if (!is_jmp)
                    begin
                        enc[0] = {HI_JCC8, cc ^ 4'h1};
                        enc[1] = ABS_JUMP_BYTES;
                        n = 2;
                    end
                    enc[n]     = OP_GRP5;
                    enc[n + 1] = MODRM_RIP;
                    for (i = 0; i < 4; i++)
                        enc[n + 2 + i] = 8'h00;
                    for (i = 0; i < 8; i++)
                        enc[n + 6 + i] = target[8 * i +: 8];
                    n  = n + 14;
                    st = ST_HANDLED;
                end
                else
                    st = ST_FAILED;
            end

            case (st)
                ST_HANDLED: relocated++;
                ST_FAILED:  failed++;
                default:    passed_over++;
            endcase

            if (n == 0)
            begin
                item = '{st, 8'h00, 1'b0, 1'b1, 17'(it.off)};
                queue_byte(item);
            end
            else
            begin
                noff = 17'(it.off) + 17'(n);
                for (i = 0; i < n; i++)
                begin
                    item = '{ST_HANDLED, enc[i], 1'b1, i == n - 1, noff};
                    queue_byte(item);
                end
            end
        endfunction

        // Compares one received result with the oldest queued byte.
        function void check_result(reloc_byte_t got);
            reloc_byte_t want;
            bytes_checked++;
            if (expected_bytes.size() == 0)
            begin
                report($sformatf("unexpected result status %0d byte %02h valid %0b last %0b off %0d",
                                 got.status, got.data, got.present, got.last, got.new_off));
                return;
            end
            want = expected_bytes.pop_front();
            if (got.status !== want.status || got.data !== want.data ||
                got.present !== want.present || got.last !== want.last ||
                got.new_off !== want.new_off)
                report($sformatf({"expected status %0d byte %02h valid %0b last %0b off %0d, ",
                                  "got status %0d byte %02h valid %0b last %0b off %0d"},
                                 want.status, want.data, want.present, want.last, want.new_off,
                                 got.status, got.data, got.present, got.last, got.new_off));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   tx_idle_on;
    bit   rx_idle_on;
    int   cycle_count;
    branch_relocation_checker sb;

    sbr_cfg_if    cfg_bus();
    sbr_instr_if  instr_bus();
    sbr_result_if result_bus();

    short_branch_relocator u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .instr  (instr_bus),
        .result (result_bus)
    );

    // Clock and cycle counter.
    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a run that does not finish in time counts as failed.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles with %0d bytes outstanding", cycle_count,
                 sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int draw_idle(bit enabled);
        return enabled ? int'($urandom_range(0, MAX_IDLE)) : 0;
    endfunction

    function automatic instr_item_t make_instr(logic [7:0] opcode, logic [7:0] disp,
                                               logic [63:0] addr, logic [3:0] len,
                                               logic [63:0] tbase, logic [15:0] off);
        instr_item_t it;
        it.opcode = opcode;
        it.disp   = disp;
        it.addr   = addr;
        it.len    = len;
        it.tbase  = tbase;
        it.off    = off;
        return it;
    endfunction

    // Mostly well-formed branches aimed at the block, at reachable trampolines and at the
    // edges of the rel32 range; the rest is noise.
    function automatic instr_item_t random_instr();
        instr_item_t it;
        int          pick;
        logic [63:0] target;
        logic [63:0] span;
        logic [63:0] size;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            it.opcode = {HI_JCC8, 4'($urandom_range(0, 15))};
        else if (pick < 65)
            it.opcode = OP_JMP8;
        else if (pick < 80)
            it.opcode = 8'($urandom_range(OP_LOOP_FIRST, OP_JCXZ));
        else
            it.opcode = 8'($urandom);
        it.disp = 8'($urandom);
        it.len  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 1))
                                              : 4'($urandom_range(2, 15));
        pick = $urandom_range(0, 99);
        if (pick < 10)
            it.off = 16'h0000;
        else if (pick < 20)
            it.off = 16'hFFFF;
        else
            it.off = 16'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 35)
            it.addr = sb.block_base - 64'd150 + 64'($urandom_range(0, 300 + sb.block_size));
        else if (pick < 45)
            it.addr = 64'($urandom_range(0, 255));
        else if (pick < 55)
            it.addr = ~64'($urandom_range(0, 255));
        else
            it.addr = {$urandom, $urandom};

        target = it.addr + 64'(it.len) + {{56{it.disp[7]}}, it.disp};
        size   = (it.opcode == OP_JMP8) ? 64'd5 : 64'd6;
        pick   = $urandom_range(0, 99);
        if (pick < 5)
            it.tbase = '0;
        else if (pick < 50)
            it.tbase = target - 64'(it.off) - 64'd524288 + 64'($urandom_range(0, 1048576));
        else if (pick < 75)
        begin
            span = ($urandom_range(0, 1) == 0) ? 64'h0000_0000_7FFF_FFFF
                                                : 64'hFFFF_FFFF_8000_0000;
            span = span + 64'($urandom_range(0, 4)) - 64'd2;
            it.tbase = target - 64'(it.off) - size - span;
        end
        else
            it.tbase = {$urandom, $urandom};
        return it;
    endfunction

    // Offers one instruction after a random gap and notes it once accepted.
    task automatic send_instr(instr_item_t it);
        int gap;
        gap = draw_idle(tx_idle_on);
        @(negedge clk);
        if (gap > 0)
        begin
            instr_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        instr_bus.valid           = 1'b1;
        instr_bus.opcode_byte     = it.opcode;
        instr_bus.displacement    = it.disp;
        instr_bus.instr_address   = it.addr;
        instr_bus.instr_length    = it.len;
        instr_bus.trampoline_base = it.tbase;
        instr_bus.write_offset    = it.off;
        do
            @(posedge clk);
        while (instr_bus.ready !== 1'b1);
        sb.note_instruction(it);
    endtask

    task automatic end_burst();
        @(negedge clk);
        instr_bus.valid = 1'b0;
    endtask

    // Waits until every queued byte has come back, then lets the pipeline settle.
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = value;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        sb.set_register(idx, value);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic apply_setting(logic [63:0] base, logic [7:0] size, logic lm);
        write_reg(REG_BLOCK_BASE, base);
        write_reg(REG_BLOCK_SIZE, 64'(size));
        write_reg(REG_LONG_MODE, 64'(lm));
        sb.settings_used++;
    endtask

    // Result side: random stalls, every accepted item checked.
    initial
    begin : result_sink
        int          stall;
        reloc_byte_t got;
        result_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_idle(rx_idle_on);
            @(negedge clk);
            if (stall > 0)
            begin
                result_bus.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_bus.ready = 1'b1;
            do
                @(posedge clk);
            while (result_bus.valid !== 1'b1);
            got.status  = status_t'(result_bus.status);
            got.data    = result_bus.out_byte;
            got.present = result_bus.byte_valid;
            got.last    = result_bus.last;
            got.new_off = result_bus.new_write_offset;
            sb.check_result(got);
        end
    end

    // Main sequence: directed cases, then random phases under different settings.
    initial
    begin : stimulus
        logic [63:0] blk;
        int          ph;
        int          k;
        sb                        = new();
        tx_idle_on                = 1'b1;
        rx_idle_on                = 1'b1;
        rst_n                     = 1'b0;
        instr_bus.valid           = 1'b0;
        instr_bus.opcode_byte     = '0;
        instr_bus.displacement    = '0;
        instr_bus.instr_address   = '0;
        instr_bus.instr_length    = '0;
        instr_bus.trampoline_base = '0;
        instr_bus.write_offset    = '0;
        cfg_bus.valid             = 1'b0;
        cfg_bus.index             = REG_BLOCK_BASE;
        cfg_bus.data              = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: empty block, long mode on.
        send_instr(make_instr(OP_JMP8, 8'h10, 64'h1000, 4'd0, 64'h2000, 16'h0000));
        send_instr(make_instr(OP_JMP8, 8'h10, 64'h1000, 4'd1, 64'h2000, 16'h0000));
        send_instr(make_instr(OP_JMP8, 8'h10, 64'h1000, 4'd2, 64'h0, 16'h0010));
        send_instr(make_instr(OP_NOP, 8'h10, 64'h1000, 4'd2, 64'h2000, 16'h0000));
        send_instr(make_instr(OP_JMP8, 8'h7F, 64'h1000, 4'd2, 64'h2000, 16'h0000));
        send_instr(make_instr({HI_JCC8, 4'h0}, 8'h80, 64'h0040_1000, 4'd2,
                              64'h0050_0000, 16'hFFFF));
        send_instr(make_instr({HI_JCC8, 4'hF}, 8'h05, 64'h0040_1000, 4'd2,
                              64'h0040_0000, 16'h1234));
        send_instr(make_instr(OP_JMP8, 8'h20, 64'hFFFF_FFFF_FFFF_FFF0, 4'd2,
                              64'h0000_7FFF_0000_0000, 16'h0040));
        send_instr(make_instr({HI_JCC8, 4'h5}, 8'hF0, 64'h1234_5678_9ABC_DEF0, 4'd2,
                              64'h0000_7FFF_0000_0000, 16'h0100));
        send_instr(make_instr(OP_LOOP_FIRST, 8'hFE, 64'h5000, 4'd2, 64'h6000, 16'h0000));
        send_instr(make_instr(OP_LOOPE, 8'h02, 64'h5000, 4'd2, 64'h6000, 16'h0000));
        send_instr(make_instr(OP_LOOP, 8'hF0, 64'h5000, 4'd2, 64'h6000, 16'h0000));
        send_instr(make_instr(OP_JCXZ, 8'h7F, 64'h5000, 4'd3, 64'h6000, 16'h0000));
        end_burst();
        wait_drained();

        // A block with long mode off: targets inside the block, just past its end and further away.
        blk = 64'h0000_7FF0_0000_0000;
        apply_setting(blk, 8'd255, 1'b0);
        send_instr(make_instr(OP_JMP8, 8'h04, blk + 64'd16, 4'd2, 64'h1000, 16'h0000));
        send_instr(make_instr(OP_LOOPE, 8'h9C, blk + 64'd100, 4'd2, 64'h1000, 16'h0000));
        send_instr(make_instr(OP_JMP8, 8'hFC, blk + 64'd2, 4'd2, 64'h1000, 16'h0000));
        send_instr(make_instr({HI_JCC8, 4'h4}, 8'h03, blk + 64'd250, 4'd2,
                              blk + 64'h1000, 16'h0020));
        send_instr(make_instr(OP_JMP8, 8'h7F, blk + 64'd200, 4'd2,
                              64'h0000_0001_0000_0000, 16'h0000));
        send_instr(make_instr({HI_JCC8, 4'hB}, 8'h7F, blk + 64'd200, 4'd2,
                              64'h0000_0001_0000_0000, 16'h0000));
        send_instr(make_instr({HI_JCC8, 4'hE}, 8'h80, blk - 64'd1000, 4'd15,
                              blk - 64'h2000, 16'hFFFF));
        send_instr(make_instr(OP_JMP8, 8'h80, blk - 64'd1000, 4'd15, blk - 64'h1000,
                              16'h8000));
        end_burst();
        wait_drained();

        // Random phases; idling is switched off on one side or both in some of them.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       apply_setting({$urandom, $urandom}, 8'($urandom_range(1, 254)), 1'b1);
                1:       apply_setting(64'h0, 8'd255, 1'b0);
                2:       apply_setting(64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 1'b1);
                3:       apply_setting(64'hFFFF_FFFF_FFFF_FF00, 8'd255, 1'b0);
                4:       apply_setting({$urandom, $urandom}, 8'd0, 1'b1);
                default: apply_setting({$urandom, $urandom}, 8'd200, 1'b0);
            endcase
            tx_idle_on = !(ph == 2 || ph == 3);
            rx_idle_on = !(ph == 1 || ph == 3);
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // Once, hold off the sender until every outstanding byte is back.
                if (ph == 0 && k == ITEMS_PER_PHASE / 2)
                begin
                    end_burst();
                    wait_drained();
                end
                send_instr(random_instr());
            end
            end_burst();
            wait_drained();
        end

        $display("Covered %0d instructions (%0d relocated, %0d failed, %0d not handled)",
                 sb.relocated + sb.failed + sb.passed_over, sb.relocated, sb.failed,
                 sb.passed_over);
        $display("over %0d register settings; %0d result items checked, %0d mismatches.",
                 sb.settings_used, sb.bytes_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/sbr_pkg.sv
src/sbr_if.sv
src/sbr_queue.sv
src/sbr_front.sv
src/sbr_back.sv
src/short_branch_relocator.sv
verif/short_branch_relocator_tb.sv
